FILE: src/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, codes, helper functions and structs of the buddy page
// allocator: bitmap word layout per order, request and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

  localparam int NUM_PAGES  = 4096;
  localparam int NUM_ORDERS = 11;
  localparam int TOP_ORDER  = NUM_ORDERS - 1;
  localparam int MAX_BLOCK  = 1 << TOP_ORDER;

  localparam int PAGE_W  = 12;
  localparam int ORDER_W = 4;
  localparam int REQ_W   = 2;
  localparam int STAT_W  = 3;
  localparam int CNT_W   = 13;

  // bitmap memory: 64 bits per word, each order starts on a word of its own
  localparam int WORD_W    = 64;
  localparam int POS_W     = 6;
  localparam int WRD_W     = PAGE_W - POS_W;
  localparam int RAM_DEPTH = 256;
  localparam int ADDR_W    = 8;

  localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESERVE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_INIT    = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK           = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_BLOCK     = 3'd1;
  localparam logic [STAT_W-1:0] ST_MISALIGNED   = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FREE     = 3'd3;
  localparam logic [STAT_W-1:0] ST_DOUBLE_FREE  = 3'd4;
  localparam logic [STAT_W-1:0] ST_INIT_REFUSED = 3'd5;
  localparam logic [STAT_W-1:0] ST_TOO_FEW      = 3'd6;
  localparam logic [STAT_W-1:0] ST_BAD_ORDER    = 3'd7;

  // number of bitmap words that order k occupies
  function automatic logic [ADDR_W-1:0] words_at(input logic [ORDER_W-1:0] k);
    int w;
    w = (NUM_PAGES >> k) >> POS_W;
    if (w == 0) begin
      w = 1;
    end
    return ADDR_W'(w);
  endfunction

  // first bitmap word of order k
  function automatic logic [ADDR_W-1:0] base_word(input logic [ORDER_W-1:0] k);
    logic [ADDR_W-1:0] b;
    b = '0;
    for (int j = 0; j < NUM_ORDERS; j++) begin
      if (ORDER_W'(j) < k) begin
        b = b + words_at(ORDER_W'(j));
      end
    end
    return b;
  endfunction

  function automatic int total_words();
    int t;
    t = 0;
    for (int j = 0; j < NUM_ORDERS; j++) begin
      t = t + int'(words_at(ORDER_W'(j)));
    end
    return t;
  endfunction

  localparam int TOTAL_WORDS = total_words();

  typedef struct packed {
    logic              re;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic              valid;
    logic [PAGE_W-1:0] page;
    logic [STAT_W-1:0] status;
  } res_t;

endpackage

`default_nettype wire

FILE: src/buddy_page_allocator_core.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator_core
// Buddy page allocator over a fixed page range, free blocks kept as one
// bitmap per order in a 64-bit wide memory.
//
//   channel  direction  handshake            beat
//   in       input      start && !busy       in_req_type, in_block_order,
//                                            in_page_number
//   out      output     out_strobe (1 cycle) out_result_page, out_status
//   cfg      input      cfg_we               cfg_wdata (page_count)
//
// Each memory step reads a word, then may modify and write it back.
// Alloc: bitmap words searched, then split orders. Free: overlap words
// checked, then merge orders. Reserve: orders searched, then split orders.
// Init: a sweep of the 131-word map, then at most one word per order.
// Bad requests answer straight from idle, without any memory step.
// After reset a clearing pass over all 256 words holds busy high.
// The result appears the cycle after the last step; it cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_page_allocator_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [bpa_pkg::REQ_W-1:0]     in_req_type,
  input  wire logic [bpa_pkg::ORDER_W-1:0]   in_block_order,
  input  wire logic [bpa_pkg::PAGE_W-1:0]    in_page_number,
  output logic                               out_strobe,
  output logic      [bpa_pkg::PAGE_W-1:0]    out_result_page,
  output logic      [bpa_pkg::STAT_W-1:0]    out_status,
  input  wire logic                          cfg_we,
  input  wire logic [bpa_pkg::CNT_W-1:0]     cfg_wdata
);

  logic [bpa_pkg::CNT_W-1:0]  page_count_r;
  logic [bpa_pkg::WORD_W-1:0] rd_data;
  bpa_pkg::ram_req_t          ram_req;
  bpa_pkg::res_t              res;
  logic                       strobe_r;
  logic [bpa_pkg::PAGE_W-1:0] page_r;
  logic [bpa_pkg::STAT_W-1:0] status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r <= bpa_pkg::CNT_W'(bpa_pkg::NUM_PAGES);
      strobe_r     <= 1'b0;
    end else begin
      strobe_r <= res.valid;
      if (cfg_we) begin
        page_count_r <= cfg_wdata;
      end
    end
  end

  // hold the last result beat
  always_ff @(posedge clk) begin
    if (res.valid) begin
      page_r   <= res.page;
      status_r <= res.status;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_result_page = page_r;
  assign out_status      = status_r;

  bpa_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .req_type    (in_req_type),
    .block_order (in_block_order),
    .page_number (in_page_number),
    .page_count  (page_count_r),
    .rd_data     (rd_data),
    .ram_req     (ram_req),
    .res         (res),
    .busy        (busy)
  );

  bpa_ram #(
    .WIDTH (bpa_pkg::WORD_W),
    .DEPTH (bpa_pkg::RAM_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.addr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.addr),
    .rdata (rd_data)
  );

endmodule

`default_nettype wire

FILE: src/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/bpa_engine.sv
// ----------------------------------------------------------------------------
// bpa_engine
// Request sequencer: walks the per-order bitmap words in memory with
// read and read-modify-write steps for alloc, free, reserve and init.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_engine (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [bpa_pkg::REQ_W-1:0]     req_type,
  input  wire logic [bpa_pkg::ORDER_W-1:0]   block_order,
  input  wire logic [bpa_pkg::PAGE_W-1:0]    page_number,
  input  wire logic [bpa_pkg::CNT_W-1:0]     page_count,
  input  wire logic [bpa_pkg::WORD_W-1:0]    rd_data,
  output bpa_pkg::ram_req_t                  ram_req,
  output bpa_pkg::res_t                      res,
  output logic                               busy
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EV    = 3'd3;
  localparam logic [2:0] S_INIT  = 3'd4;

  localparam logic [2:0] PH_ALLOC = 3'd0;
  localparam logic [2:0] PH_DFREE = 3'd1;
  localparam logic [2:0] PH_MERGE = 3'd2;
  localparam logic [2:0] PH_RSV   = 3'd3;
  localparam logic [2:0] PH_SPLIT = 3'd4;
  localparam logic [2:0] PH_ANY   = 3'd5;

  localparam logic [bpa_pkg::ORDER_W-1:0] TOP =
    bpa_pkg::ORDER_W'(bpa_pkg::TOP_ORDER);

  logic [2:0]                    state_r, state_nxt;
  logic [2:0]                    ph_r, ph_nxt;
  logic [bpa_pkg::ORDER_W-1:0]   ord_r, ord_nxt;
  logic [bpa_pkg::ORDER_W-1:0]   stop_r, stop_nxt;
  logic [bpa_pkg::WRD_W-1:0]     wrd_r, wrd_nxt;
  logic [bpa_pkg::ADDR_W-1:0]    sweep_r, sweep_nxt;
  logic [bpa_pkg::PAGE_W-1:0]    blk_r, blk_nxt;
  logic [bpa_pkg::PAGE_W-1:0]    page_r, page_nxt;
  logic [bpa_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [bpa_pkg::REQ_W-1:0]     op_r, op_nxt;

  logic [bpa_pkg::ORDER_W-1:0]   k_c;
  logic [bpa_pkg::PAGE_W-1:0]    idx_c;
  logic [bpa_pkg::WRD_W-1:0]     off_c;
  logic [bpa_pkg::POS_W-1:0]     pos_c;
  logic [bpa_pkg::ADDR_W-1:0]    addr_c;
  logic [bpa_pkg::WORD_W-1:0]    bit_c;
  logic [bpa_pkg::WORD_W-1:0]    mask_c;
  logic [bpa_pkg::WRD_W-1:0]     wlast_c;
  logic [bpa_pkg::ORDER_W-1:0]   diff_c;
  logic                          below_c;
  logic [bpa_pkg::POS_W-1:0]     ffs_c;
  logic [bpa_pkg::CNT_W-1:0]     size_c;
  logic                          accept;

  function automatic logic [bpa_pkg::POS_W-1:0] ffs(input logic [bpa_pkg::WORD_W-1:0] v);
    logic [bpa_pkg::POS_W-1:0] p;
    p = '0;
    for (int i = bpa_pkg::WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        p = bpa_pkg::POS_W'(i);
      end
    end
    return p;
  endfunction

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // word address of the current step
  always_comb begin
    k_c   = ord_r;
    idx_c = '0;
    off_c = '0;
    unique case (ph_r)
      PH_ALLOC: begin
        off_c = wrd_r;
      end
      PH_DFREE: begin
        idx_c = page_r >> ord_r;
        off_c = wrd_r;
      end
      PH_MERGE: begin
        idx_c = blk_r >> ord_r;
      end
      PH_RSV: begin
        idx_c = page_r >> ord_r;
      end
      PH_SPLIT: begin
        k_c   = ord_r - bpa_pkg::ORDER_W'(1);
        idx_c = (blk_r >> k_c) ^ bpa_pkg::PAGE_W'(1);
      end
      default: begin
        idx_c = '0;
      end
    endcase
    if (state_r == S_INIT && ord_r != TOP) begin
      idx_c = bpa_pkg::PAGE_W'(cnt_r >> ord_r) & ~bpa_pkg::PAGE_W'(1);
    end
    pos_c = idx_c[bpa_pkg::POS_W-1:0];
    bit_c = bpa_pkg::WORD_W'(1) << pos_c;
    if (state_r == S_CLEAR || ph_r == PH_ANY && state_r != S_INIT) begin
      addr_c = sweep_r;
    end else begin
      addr_c = bpa_pkg::base_word(k_c)
             + bpa_pkg::ADDR_W'(idx_c[bpa_pkg::PAGE_W-1:bpa_pkg::POS_W])
             + bpa_pkg::ADDR_W'(off_c);
    end
  end

  // overlap window of the freed block at order ord_r
  always_comb begin
    below_c = (ord_r < stop_r);
    diff_c  = stop_r - ord_r;
    wlast_c = '0;
    mask_c  = bit_c;
    if (below_c) begin
      if (diff_c >= bpa_pkg::ORDER_W'(bpa_pkg::POS_W)) begin
        mask_c  = '1;
        wlast_c = bpa_pkg::WRD_W'((32'd1 << (diff_c - bpa_pkg::ORDER_W'(bpa_pkg::POS_W)))
                                  - 32'd1);
      end else begin
        mask_c = ((bpa_pkg::WORD_W'(1) << (bpa_pkg::WORD_W'(1) << diff_c))
                  - bpa_pkg::WORD_W'(1)) << pos_c;
      end
    end
  end

  assign ffs_c  = ffs(rd_data);
  assign size_c = bpa_pkg::CNT_W'(1) << block_order;

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    ord_nxt   = ord_r;
    stop_nxt  = stop_r;
    wrd_nxt   = wrd_r;
    sweep_nxt = sweep_r;
    blk_nxt   = blk_r;
    page_nxt  = page_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    ram_req   = '{re: 1'b0, we: 1'b0, addr: addr_c, wdata: '0};
    res       = '{valid: 1'b0, page: '0, status: bpa_pkg::ST_OK};

    unique case (state_r)
      S_CLEAR: begin
        ram_req.we = 1'b1;
        sweep_nxt  = sweep_r + bpa_pkg::ADDR_W'(1);
        if (sweep_r == bpa_pkg::ADDR_W'(bpa_pkg::RAM_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          op_nxt   = req_type;
          page_nxt = page_number;
          wrd_nxt  = '0;
          unique case (req_type)
            bpa_pkg::REQ_ALLOC: begin
              if (block_order >= bpa_pkg::ORDER_W'(bpa_pkg::NUM_ORDERS)) begin
                res.valid  = 1'b1;
                res.status = bpa_pkg::ST_BAD_ORDER;
              end else begin
                ph_nxt    = PH_ALLOC;
                ord_nxt   = block_order;
                stop_nxt  = block_order;
                state_nxt = S_RD;
              end
            end
            bpa_pkg::REQ_FREE: begin
              if (block_order >= bpa_pkg::ORDER_W'(bpa_pkg::NUM_ORDERS)) begin
                res.valid  = 1'b1;
                res.status = bpa_pkg::ST_BAD_ORDER;
              end else if ((page_number & bpa_pkg::PAGE_W'(size_c - bpa_pkg::CNT_W'(1)))
                           != '0 ||
                           ({1'b0, page_number} + size_c) >
                           bpa_pkg::CNT_W'(bpa_pkg::NUM_PAGES)) begin
                res.valid  = 1'b1;
                res.status = bpa_pkg::ST_MISALIGNED;
              end else begin
                ph_nxt    = PH_DFREE;
                ord_nxt   = '0;
                stop_nxt  = block_order;
                state_nxt = S_RD;
              end
            end
            bpa_pkg::REQ_RESERVE: begin
              if ({1'b0, page_number} >= bpa_pkg::CNT_W'(bpa_pkg::NUM_PAGES)) begin
                res.valid  = 1'b1;
                res.status = bpa_pkg::ST_NOT_FREE;
              end else begin
                ph_nxt    = PH_RSV;
                ord_nxt   = TOP;
                stop_nxt  = '0;
                state_nxt = S_RD;
              end
            end
            bpa_pkg::REQ_INIT: begin
              ph_nxt    = PH_ANY;
              sweep_nxt = '0;
              cnt_nxt   = (page_count > bpa_pkg::CNT_W'(bpa_pkg::NUM_PAGES)) ?
                          bpa_pkg::CNT_W'(bpa_pkg::NUM_PAGES) : page_count;
              state_nxt = S_RD;
            end
          endcase
        end
      end

      S_RD: begin
        ram_req.re = 1'b1;
        state_nxt  = S_EV;
      end

      S_EV: begin
        state_nxt = S_RD;
        unique case (ph_r)
          PH_ALLOC: begin
            if (rd_data != '0) begin
              ram_req.we    = 1'b1;
              ram_req.wdata = rd_data & ~(bpa_pkg::WORD_W'(1) << ffs_c);
              blk_nxt       = {wrd_r, ffs_c} << ord_r;
              if (ord_r > stop_r) begin
                ph_nxt = PH_SPLIT;
              end else begin
                state_nxt = S_IDLE;
                res.valid = 1'b1;
                res.page  = {wrd_r, ffs_c} << ord_r;
              end
            end else if (wrd_r == bpa_pkg::WRD_W'(bpa_pkg::words_at(ord_r)
                                                   - bpa_pkg::ADDR_W'(1))) begin
              wrd_nxt = '0;
              if (ord_r == TOP) begin
                state_nxt  = S_IDLE;
                res.valid  = 1'b1;
                res.status = bpa_pkg::ST_NO_BLOCK;
              end else begin
                ord_nxt = ord_r + bpa_pkg::ORDER_W'(1);
              end
            end else begin
              wrd_nxt = wrd_r + bpa_pkg::WRD_W'(1);
            end
          end

          PH_SPLIT: begin
            // hand the sibling half back one order down
            ram_req.we    = 1'b1;
            ram_req.wdata = rd_data | bit_c;
            ord_nxt       = k_c;
            if (k_c == stop_r) begin
              state_nxt = S_IDLE;
              res.valid = 1'b1;
              res.page  = (op_r == bpa_pkg::REQ_ALLOC) ? blk_r : '0;
            end
          end

          PH_DFREE: begin
            if ((rd_data & mask_c) != '0) begin
              state_nxt  = S_IDLE;
              res.valid  = 1'b1;
              res.status = bpa_pkg::ST_DOUBLE_FREE;
            end else if (wrd_r != wlast_c) begin
              wrd_nxt = wrd_r + bpa_pkg::WRD_W'(1);
            end else if (ord_r == TOP) begin
              ph_nxt  = PH_MERGE;
              ord_nxt = stop_r;
              blk_nxt = page_r;
              wrd_nxt = '0;
            end else begin
              ord_nxt = ord_r + bpa_pkg::ORDER_W'(1);
              wrd_nxt = '0;
            end
          end

          PH_MERGE: begin
            ram_req.we = 1'b1;
            if (ord_r != TOP && rd_data[pos_c ^ bpa_pkg::POS_W'(1)]) begin
              ram_req.wdata = rd_data & ~(bpa_pkg::WORD_W'(1) << (pos_c ^ bpa_pkg::POS_W'(1)));
              blk_nxt       = blk_r & ~(bpa_pkg::PAGE_W'(1) << ord_r);
              ord_nxt       = ord_r + bpa_pkg::ORDER_W'(1);
            end else begin
              ram_req.wdata = rd_data | bit_c;
              state_nxt     = S_IDLE;
              res.valid     = 1'b1;
            end
          end

          PH_RSV: begin
            if (rd_data[pos_c]) begin
              ram_req.we    = 1'b1;
              ram_req.wdata = rd_data & ~bit_c;
              if (ord_r != '0) begin
                ph_nxt  = PH_SPLIT;
                blk_nxt = page_r;
              end else begin
                state_nxt = S_IDLE;
                res.valid = 1'b1;
              end
            end else if (ord_r == '0) begin
              state_nxt  = S_IDLE;
              res.valid  = 1'b1;
              res.status = bpa_pkg::ST_NOT_FREE;
            end else begin
              ord_nxt = ord_r - bpa_pkg::ORDER_W'(1);
            end
          end

          default: begin
            // any-free sweep ahead of init
            if (rd_data != '0) begin
              state_nxt  = S_IDLE;
              res.valid  = 1'b1;
              res.status = bpa_pkg::ST_INIT_REFUSED;
            end else if (sweep_r == bpa_pkg::ADDR_W'(bpa_pkg::TOTAL_WORDS - 1)) begin
              if (cnt_r < bpa_pkg::CNT_W'(bpa_pkg::MAX_BLOCK)) begin
                state_nxt  = S_IDLE;
                res.valid  = 1'b1;
                res.status = bpa_pkg::ST_TOO_FEW;
              end else begin
                state_nxt = S_INIT;
                ord_nxt   = TOP;
              end
            end else begin
              sweep_nxt = sweep_r + bpa_pkg::ADDR_W'(1);
            end
          end
        endcase
      end

      default: begin
        // In S_INIT the map is known empty: write at most one word per order
        if (ord_r == TOP) begin
          ram_req.we    = 1'b1;
          ram_req.wdata = (bpa_pkg::WORD_W'(1) << (cnt_r >> TOP)) - bpa_pkg::WORD_W'(1);
        end else if (cnt_r[ord_r]) begin
          ram_req.we    = 1'b1;
          ram_req.wdata = bit_c;
        end
        if (ord_r == '0) begin
          state_nxt = S_IDLE;
          res.valid = 1'b1;
        end else begin
          ord_nxt = ord_r - bpa_pkg::ORDER_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      sweep_r <= '0;
      ph_r    <= PH_ALLOC;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      ph_r    <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ord_r  <= ord_nxt;
    stop_r <= stop_nxt;
    wrd_r  <= wrd_nxt;
    blk_r  <= blk_nxt;
    page_r <= page_nxt;
    cnt_r  <= cnt_nxt;
    op_r   <= op_nxt;
  end

endmodule

`default_nettype wire

FILE: src/bpa_checker.sv
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks of the buddy page allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic [bpa_pkg::REQ_W-1:0]   in_req_type,
  input wire logic [bpa_pkg::ORDER_W-1:0] in_block_order,
  input wire logic                        out_strobe,
  input wire logic [bpa_pkg::PAGE_W-1:0]  out_result_page,
  input wire logic [bpa_pkg::STAT_W-1:0]  out_status
);

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("not busy after reset");

  // an accepted beat keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_strobe)
    else $error("accepted beat dropped");

  a_bad_order: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req_type == bpa_pkg::REQ_ALLOC &&
    in_block_order >= bpa_pkg::ORDER_W'(bpa_pkg::NUM_ORDERS)
    |=> out_strobe && out_status == bpa_pkg::ST_BAD_ORDER)
    else $error("bad order not reported");

  a_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != bpa_pkg::ST_OK |-> out_result_page == '0)
    else $error("page on failed request");

endmodule

bind buddy_page_allocator_core bpa_checker u_bpa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_req_type     (in_req_type),
  .in_block_order  (in_block_order),
  .out_strobe      (out_strobe),
  .out_result_page (out_result_page),
  .out_status      (out_status)
);

`default_nettype wire
